[src/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define ACSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ACSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[src/acsc_pkg.sv]
// Shared constants and types of the allele chi-square strand check.
package acsc_pkg;
	localparam int CNT_W = 16;
	localparam int NSUM_W = CNT_W + 2;
	localparam int CHI_W = 25;
	localparam logic [CHI_W-1:0] CHI_MAX = {CHI_W{1'b1}};
	localparam logic [CHI_W-1:0] THRESH_RESET = 25'd3873;
	localparam int LANES = 4;
	localparam int QUO_W = 28;
	localparam int LANE_LAT = 4 + QUO_W;
	localparam int IN_W = 2 * LANES * CNT_W;
	localparam int OUT_W = 56;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CHI_W-1:0] chi_t;

	typedef struct packed {
		chi_t value;
		chi_t flipped;
		logic mismatch;
		logic strand_flip;
	} result_t;
endpackage

[src/acsc_lane.sv]
// One chi-square term lane: products, squared difference and a pipelined divider.
module acsc_lane (
	input  logic clk,
	input  logic en,
	input  acsc_pkg::cnt_t a,
	input  acsc_pkg::cnt_t b,
	input  logic [acsc_pkg::NSUM_W-1:0] na,
	input  logic [acsc_pkg::NSUM_W-1:0] nb,
	output acsc_pkg::chi_t term
);
	localparam int NW = acsc_pkg::NSUM_W;
	localparam int DW = acsc_pkg::CNT_W + NW;
	localparam int HW = DW / 2;
	localparam int TW = acsc_pkg::CNT_W + 1;
	localparam int DENW = TW + 2 * NW;
	localparam int SQW = 2 * DW;
	localparam int RW = SQW + 11;
	localparam int QW = acsc_pkg::QUO_W;
	localparam int VW = DENW + 1 + QW;

	logic [DW-1:0] x_s1, y_s1, d_s2;
	logic [TW+NW-1:0] tn_s1;
	logic [NW-1:0] nb_s1;
	logic zero_s1, zero_s2, zero_s3, zero_s4;
	logic [DENW-1:0] den_s2, den_s3;
	logic [2*HW-1:0] phh_s3, phl_s3, pll_s3;
	logic [SQW-1:0] sq;
	logic [RW-1:0] rem_q [0:QW];
	logic [QW-1:0] quo_q [0:QW];
	logic [DENW:0] div_q [0:QW];
	logic zero_q [0:QW];
	logic [TW-1:0] t_sum;

	assign t_sum = {1'b0, a} + {1'b0, b};

	// Cross products and the first factor of the denominator.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= DW'(a * nb);
			y_s1 <= DW'(b * na);
			tn_s1 <= (TW+NW)'(t_sum * na);
			nb_s1 <= nb;
			zero_s1 <= (t_sum == '0) || (na == '0) || (nb == '0);
		end
	end

	// Absolute difference and the full denominator.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= (x_s1 > y_s1) ? x_s1 - y_s1 : y_s1 - x_s1;
			den_s2 <= DENW'(tn_s1 * nb_s1);
			zero_s2 <= zero_s1;
		end
	end

	// Square of the difference split into half-width partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			phh_s3 <= d_s2[DW-1:HW] * d_s2[DW-1:HW];
			phl_s3 <= d_s2[DW-1:HW] * d_s2[HW-1:0];
			pll_s3 <= d_s2[HW-1:0] * d_s2[HW-1:0];
			den_s3 <= den_s2;
			zero_s3 <= zero_s2;
		end
	end

	assign sq = (SQW'(phh_s3) << (2 * HW)) + (SQW'(phl_s3) << (HW + 1)) + SQW'(pll_s3);

	// Rounded dividend 512*d^2 + den over divisor 2*den.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= (RW'(sq) << 9) + RW'(den_s3);
			div_q[0] <= {den_s3, 1'b0};
			quo_q[0] <= '0;
			zero_s4 <= zero_s3;
		end
	end
	assign zero_q[0] = zero_s4;

	// One quotient bit per stage, most significant first.
	for (genvar g = 0; g < QW; g++) begin : g_div
		localparam int K = QW - 1 - g;
		logic [VW:0] shifted;
		logic take;
		logic zq;
		assign shifted = (VW+1)'(div_q[g]) << K;
		assign take = {1'b0, (VW)'(rem_q[g])} >= shifted;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g+1] <= take ? RW'({1'b0, (VW)'(rem_q[g])} - shifted) : rem_q[g];
				quo_q[g+1] <= quo_q[g] | (take ? (QW'(1) << K) : '0);
				div_q[g+1] <= div_q[g];
				zq <= zero_q[g];
			end
		end
		assign zero_q[g+1] = zq;
	end

	// Empty denominators give zero; large terms clip.
	always_comb begin
		if (zero_q[QW]) begin
			term = '0;
		end else if (quo_q[QW] > QW'(acsc_pkg::CHI_MAX)) begin
			term = acsc_pkg::CHI_MAX;
		end else begin
			term = quo_q[QW][acsc_pkg::CHI_W-1:0];
		end
	end
endmodule

[src/acsc_merge.sv]
// Merge stage: sums lane terms, saturates and sets the flags.
module acsc_merge (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  acsc_pkg::chi_t dir_term [acsc_pkg::LANES],
	input  acsc_pkg::chi_t flp_term [acsc_pkg::LANES],
	input  acsc_pkg::chi_t threshold,
	output logic out_valid,
	output acsc_pkg::result_t result
);
	localparam int SW = acsc_pkg::CHI_W + 2;

	logic v_s1, out_valid_q;
	acsc_pkg::chi_t dir_s1, flp_s1;
	acsc_pkg::result_t result_q;
	logic [SW-1:0] dsum, fsum;

	always_comb begin
		dsum = '0;
		fsum = '0;
		for (int i = 0; i < acsc_pkg::LANES; i++) begin
			dsum = dsum + SW'(dir_term[i]);
			fsum = fsum + SW'(flp_term[i]);
		end
	end

	// Valid bits of the two merge registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			out_valid_q <= v_s1;
		end
	end

	// Saturated sums, then flags into the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			dir_s1 <= (dsum > SW'(acsc_pkg::CHI_MAX)) ? acsc_pkg::CHI_MAX : dsum[acsc_pkg::CHI_W-1:0];
			flp_s1 <= (fsum > SW'(acsc_pkg::CHI_MAX)) ? acsc_pkg::CHI_MAX : fsum[acsc_pkg::CHI_W-1:0];
			result_q.value <= dir_s1;
			result_q.flipped <= flp_s1;
			result_q.mismatch <= dir_s1 > threshold;
			result_q.strand_flip <= flp_s1 < dir_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign result = result_q;
endmodule

[src/allele_chisq_strand_check.sv]
// Top level of the allele chi-square strand check.
// Usage: one marker enters per transaction on the s_axis channel; tdata carries the
// eight 16-bit counts, first panel A, C, G, T then second panel A, C, G, T.
// Each marker yields one transaction on m_axis carrying the direct and the
// strand-flipped chi-square (8 fraction bits, saturated) and the two flags.
// From the accepting edge, where the input register loads, a marker passes 32 lane
// stages (four multiply stages and a 28-stage restoring divider that retires one
// quotient bit per stage) and two merge registers. Eight lanes, four per table, run
// in parallel; throughput is one marker per cycle unless the receiver stalls.
// When the receiver stalls with a result pending, the whole pipeline holds and
// s_axis_tready drops; it accepts again in the cycle the result is taken.
// Reset clears all valid bits and sets the mismatch threshold to 15.13. The user must
// write the threshold through cfg_wen and cfg_wdata while idle; this is not enforced.
module allele_chisq_strand_check (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic [acsc_pkg::CHI_W-1:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// panel_a_count_a, _c, _g, _t, panel_b_count_a, _c, _g, _t (16 bits each)
	input  logic [acsc_pkg::IN_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// chisq_value[24:0], chisq_flipped[49:25], mismatch_flag[50], strand_flip_flag[51]
	output logic [acsc_pkg::OUT_W-1:0] m_axis_tdata
);
	localparam int L = acsc_pkg::LANES;
	localparam int CW = acsc_pkg::CNT_W;
	localparam int NW = acsc_pkg::NSUM_W;

	logic en, valid_s1, lanes_valid, out_valid;
	logic [acsc_pkg::LANE_LAT-1:0] vpipe_q;
	acsc_pkg::cnt_t a_s1 [L];
	acsc_pkg::cnt_t b_s1 [L];
	logic [NW-1:0] na_s1, nb_s1, na_in, nb_in;
	acsc_pkg::chi_t threshold_q;
	acsc_pkg::chi_t dir_term [L];
	acsc_pkg::chi_t flp_term [L];
	acsc_pkg::result_t result;

	assign en = !out_valid || m_axis_tready;
	assign s_axis_tready = en;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= acsc_pkg::THRESH_RESET;
		end else if (cfg_wen) begin
			threshold_q <= cfg_wdata;
		end
	end

	// Panel totals of the incoming marker.
	always_comb begin
		na_in = '0;
		nb_in = '0;
		for (int j = 0; j < L; j++) begin
			na_in = na_in + NW'(s_axis_tdata[j*CW +: CW]);
			nb_in = nb_in + NW'(s_axis_tdata[(L+j)*CW +: CW]);
		end
	end

	// Input register and the valid chain that follows the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			vpipe_q <= '0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
			vpipe_q <= {vpipe_q[acsc_pkg::LANE_LAT-2:0], valid_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en && s_axis_tvalid) begin
			for (int j = 0; j < L; j++) begin
				a_s1[j] <= s_axis_tdata[j*CW +: CW];
				b_s1[j] <= s_axis_tdata[(L+j)*CW +: CW];
			end
			na_s1 <= na_in;
			nb_s1 <= nb_in;
		end
	end

	assign lanes_valid = vpipe_q[acsc_pkg::LANE_LAT-1];

	// Direct lanes and lanes with the first panel complemented (A<->T, C<->G).
	for (genvar j = 0; j < L; j++) begin : g_lane
		acsc_lane u_dir (
			.clk(clk), .en(en), .a(a_s1[j]), .b(b_s1[j]),
			.na(na_s1), .nb(nb_s1), .term(dir_term[j])
		);
		acsc_lane u_flp (
			.clk(clk), .en(en), .a(a_s1[L-1-j]), .b(b_s1[j]),
			.na(na_s1), .nb(nb_s1), .term(flp_term[j])
		);
	end

	acsc_merge u_merge (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(lanes_valid),
		.dir_term(dir_term), .flp_term(flp_term), .threshold(threshold_q),
		.out_valid(out_valid), .result(result)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata = {4'b0, result.strand_flip, result.mismatch,
		result.flipped, result.value};
endmodule

[src/acsc_checker.sv]
// Port-level checker of the allele chi-square strand check, bound to the top level.
`include "assert_macros.svh"
module acsc_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [acsc_pkg::IN_W-1:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [acsc_pkg::OUT_W-1:0] m_axis_tdata
);
	// A pending result stays offered until taken.
	`ACSC_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	// A stalled result keeps its payload.
	`ACSC_ASSERT_NEXT(a_hold_data, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	// The strand flag agrees with the two values it compares.
	`ACSC_ASSERT_SAME(a_flip_flag, clk, arst_n, m_axis_tvalid, m_axis_tdata[51] == (m_axis_tdata[49:25] < m_axis_tdata[24:0]))
	// The input side is stalled while a result waits.
	`ACSC_ASSERT_SAME(a_stall, clk, arst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
endmodule

bind allele_chisq_strand_check acsc_checker u_acsc_checker (.*);

[verif/acsc_result_checker.sv]
// Checker that predicts and compares the chi-square results of the strand check.
`timescale 1ns / 1ps

module acsc_result_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic [acsc_pkg::CHI_W-1:0] cfg_wdata,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [acsc_pkg::IN_W-1:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [acsc_pkg::OUT_W-1:0] m_axis_tdata,
	output int fail_count,
	output int results_pending
);
	acsc_pkg::chi_t threshold;
	acsc_pkg::result_t expected_results[$];

	// Rounded 256*d*d/den with ties upward, clipped to the output range.
	function automatic acsc_pkg::chi_t scaled_term(input logic [127:0] d,
		input logic [127:0] den);
		logic [127:0] q;
		q = ((d * d) * 128'd512 + den) / (den * 128'd2);
		return (q > acsc_pkg::CHI_MAX) ? acsc_pkg::CHI_MAX : q[acsc_pkg::CHI_W-1:0];
	endfunction

	// Pearson chi-square of the 2x4 table, with absent alleles and empty panels as zero.
	function automatic acsc_pkg::chi_t table_chisq(input logic [3:0][15:0] a,
		input logic [3:0][15:0] b);
		logic [127:0] na, nb, t, x, y, d, total;
		na = 0;
		nb = 0;
		total = 0;
		for (int j = 0; j < 4; j++) begin
			na += a[j];
			nb += b[j];
		end
		if (na == 0 || nb == 0)
			return '0;
		for (int j = 0; j < 4; j++) begin
			t = a[j] + b[j];
			if (t != 0) begin
				x = a[j] * nb;
				y = b[j] * na;
				d = (x > y) ? x - y : y - x;
				total += scaled_term(d, t * na * nb);
			end
		end
		return (total > acsc_pkg::CHI_MAX) ? acsc_pkg::CHI_MAX : total[acsc_pkg::CHI_W-1:0];
	endfunction

	// Work out the result of one marker from its packed counts.
	function automatic acsc_pkg::result_t marker_result(
		input logic [acsc_pkg::IN_W-1:0] counts);
		logic [3:0][15:0] a, b, af;
		acsc_pkg::result_t r;
		for (int j = 0; j < 4; j++) begin
			a[j] = counts[16*j +: 16];
			b[j] = counts[64 + 16*j +: 16];
		end
		for (int j = 0; j < 4; j++)
			af[j] = a[3-j];
		r.value = table_chisq(a, b);
		r.flipped = table_chisq(af, b);
		r.mismatch = r.value > threshold;
		r.strand_flip = r.flipped < r.value;
		return r;
	endfunction

	// Track the threshold, queue predictions and compare each result transaction.
	always @(posedge clk or negedge arst_n) begin
		acsc_pkg::result_t got, exp_r;
		if (!arst_n) begin
			threshold <= acsc_pkg::THRESH_RESET;
			fail_count <= 0;
			expected_results.delete();
			results_pending <= 0;
		end else begin
			if (cfg_wen)
				threshold <= cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(marker_result(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got.value = m_axis_tdata[24:0];
				got.flipped = m_axis_tdata[49:25];
				got.mismatch = m_axis_tdata[50];
				got.strand_flip = m_axis_tdata[51];
				if (expected_results.size() == 0) begin
					$error("result transaction with no marker outstanding");
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got != exp_r)
						fail_count <= fail_count + 1;
					if (got.value != exp_r.value)
						$error("chisq_value expected %0d got %0d", exp_r.value, got.value);
					if (got.flipped != exp_r.flipped)
						$error("chisq_flipped expected %0d got %0d",
							exp_r.flipped, got.flipped);
					if (got.mismatch != exp_r.mismatch)
						$error("mismatch_flag expected %0d got %0d",
							exp_r.mismatch, got.mismatch);
					if (got.strand_flip != exp_r.strand_flip)
						$error("strand_flip_flag expected %0d got %0d",
							exp_r.strand_flip, got.strand_flip);
				end
			end
			results_pending <= expected_results.size();
		end
	end
endmodule

[verif/testbench.sv]
// Top of the testbench: stimulus, flow control and verdict for the strand check.
`timescale 1ns / 1ps

module testbench;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 3 * acsc_pkg::LANE_LAT;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [acsc_pkg::CHI_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [acsc_pkg::IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [acsc_pkg::OUT_W-1:0] m_axis_tdata;
	logic marker_taken = 1'b0;
	logic hold_off_req = 1'b0;
	logic sink_always_ready = 1'b0;
	int fail_count;
	int results_pending;
	int cycle_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	allele_chisq_strand_check u_top (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
	);

	acsc_result_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count), .results_pending(results_pending)
	);

	// Note each accepted input transaction for the driver.
	always @(posedge clk) begin
		marker_taken <= s_axis_tvalid && s_axis_tready;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("allele_chisq_strand_check: mismatch");
			$finish;
		end
	end

	// Receiver: random stall pattern, runs of full readiness, and requested long hold-offs.
	initial begin
		int mode;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_axis_tready = 1'b0;
				repeat (300) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (sink_always_ready) begin
				m_axis_tready = 1'b1;
			end else begin
				mode = $urandom_range(0, 9);
				m_axis_tready = (mode < 6);
				if (mode == 9)
					m_axis_tready = ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Offer one marker and hold it until it is accepted.
	task automatic offer_marker(input logic [3:0][15:0] a, input logic [3:0][15:0] b);
		s_axis_tdata = {b, a};
		s_axis_tvalid = 1'b1;
		do @(negedge clk); while (!marker_taken);
	endtask

	task automatic idle_cycles(input int n);
		s_axis_tvalid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid = 1'b0;
		while (results_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [acsc_pkg::CHI_W-1:0] value);
		drain_results();
		cfg_wdata = value;
		cfg_wen = 1'b1;
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	function automatic logic [15:0] rand_count();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 16'd0;
		if (sel < 5) return 16'($urandom_range(0, 60));
		if (sel < 8) return 16'($urandom_range(0, 4000));
		return 16'($urandom_range(0, 65535));
	endfunction

	// Random marker: some similar panels, some complementary, some with absent alleles, the rest noise.
	task automatic random_marker();
		logic [3:0][15:0] a, b;
		int shape;
		shape = $urandom_range(0, 9);
		for (int j = 0; j < 4; j++) begin
			a[j] = rand_count();
			b[j] = rand_count();
		end
		if (shape < 3) begin
			for (int j = 0; j < 4; j++)
				b[j] = a[j] + 16'($urandom_range(0, 8));
		end else if (shape < 5) begin
			for (int j = 0; j < 4; j++)
				b[j] = a[3-j] + 16'($urandom_range(0, 8));
		end else if (shape == 5) begin
			a[2'($urandom_range(0, 3))] = 16'd0;
			b[2'($urandom_range(0, 3))] = 16'd0;
		end
		offer_marker(a, b);
	endtask

	task automatic random_run(input int n_markers);
		for (int i = 0; i < n_markers; i++) begin
			random_marker();
			if ($urandom_range(0, 7) == 0)
				idle_cycles($urandom_range(1, 12));
		end
	endtask

	initial begin
		logic [15:0] m;
		m = 16'hFFFF;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed markers at the reset threshold.
		offer_marker('0, '0);
		offer_marker('0, {m, m, m, m});
		offer_marker({m, m, m, m}, '0);
		offer_marker({m, m, m, m}, {m, m, m, m});
		offer_marker({16'd0, 16'd0, m, m}, {m, m, 16'd0, 16'd0});
		offer_marker({16'd0, 16'd0, 16'd0, m}, {m, m, m, 16'd0});
		offer_marker({16'd0, 16'd0, 16'd0, 16'd1}, {16'd0, 16'd0, 16'd0, 16'd1});
		offer_marker({16'd0, 16'd0, 16'd0, 16'd1}, {16'd1, 16'd0, 16'd0, 16'd0});
		offer_marker({16'd0, 16'd9, 16'd0, 16'd30}, {16'd30, 16'd0, 16'd9, 16'd0});
		offer_marker({16'd5, 16'd0, 16'd7, 16'd3}, {16'd5, 16'd0, 16'd7, 16'd3});
		offer_marker({16'd1, 16'd2, 16'd3, 16'd4}, {16'd4, 16'd3, 16'd2, 16'd1});
		offer_marker({16'd0, 16'd0, 16'd1, 16'd1}, {16'd1, 16'd1, 16'd0, 16'd0});
		offer_marker({16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00},
			{16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF});
		offer_marker({16'd0, 16'd0, 16'd40, 16'd60}, {16'd0, 16'd0, 16'd55, 16'd45});

		// Random markers across several thresholds, the extremes among them.
		random_run(250);
		write_threshold('0);
		offer_marker({16'd5, 16'd0, 16'd7, 16'd3}, {16'd5, 16'd0, 16'd7, 16'd3});
		offer_marker({16'd0, 16'd0, 16'd0, 16'd1}, {16'd1, 16'd0, 16'd0, 16'd0});
		random_run(250);
		write_threshold(acsc_pkg::CHI_MAX);
		offer_marker({16'd0, 16'd0, m, m}, {m, m, 16'd0, 16'd0});
		random_run(250);

		// Long receiver hold-off while the sender keeps offering.
		write_threshold(25'd1);
		hold_off_req = 1'b1;
		for (int i = 0; i < 120; i++)
			random_marker();
		random_run(130);

		// Sender pauses until everything is out, then a stretch with no receiver stalls.
		write_threshold(25'($urandom_range(0, 33554431)));
		sink_always_ready = 1'b1;
		random_run(200);
		drain_results();
		sink_always_ready = 1'b0;
		write_threshold(acsc_pkg::THRESH_RESET + 25'd128);
		random_run(240);

		drain_results();
		if (fail_count == 0)
			$display("allele_chisq_strand_check: match");
		else
			$display("allele_chisq_strand_check: mismatch");
		$finish;
	end
endmodule
